// ===== design/assert_macros.svh =====
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked when out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
// Next-cycle implication, checked when out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/fsup_pkg.sv =====
// Shared types and constants of the fault supervisor.
package fsup_pkg;

	localparam int unsigned GOOD_SAMPLES_NEEDED = 5;
	localparam int unsigned STREAK_W = 8;

	typedef enum logic [2:0] {
		REG_SENSOR_LOW   = 3'd0,
		REG_SENSOR_HIGH  = 3'd1,
		REG_SENSOR_STEP  = 3'd2,
		REG_WARN_LEVEL   = 3'd3,
		REG_SENSOR_DEADL = 3'd4,
		REG_COMMS_DEADL  = 3'd5,
		REG_COOLDOWN     = 3'd6,
		REG_RETRY_LIMIT  = 3'd7
	} reg_idx_t;

	// fault_bits positions
	localparam int unsigned FB_TIMEOUT     = 0;
	localparam int unsigned FB_IMPLAUSIBLE = 1;
	localparam int unsigned FB_RATE        = 2;
	localparam int unsigned FB_COMMS       = 3;
	localparam int unsigned FB_OVERFLOW    = 4;
	localparam int unsigned FB_TASK        = 5;

	typedef struct packed {
		logic signed [15:0] sensor_low;
		logic signed [15:0] sensor_high;
		logic        [15:0] sensor_step;
		logic signed [15:0] warn_level;
		logic        [31:0] sensor_deadline;
		logic        [31:0] comms_deadline;
		logic        [31:0] cooldown;
		logic        [3:0]  retry_limit;
	} cfg_t;

	typedef struct packed {
		logic [31:0]        tick_time;
		logic               sample_fresh;
		logic signed [15:0] sample_value;
		logic               cmd_fresh;
		logic               queue_overflow;
		logic               task_missed;
		logic               manual_clear;
	} tick_t;

	// sample/command history seen by the detectors
	typedef struct packed {
		logic [31:0]        last_sample_time;
		logic [31:0]        last_command_time;
		logic signed [15:0] last_good_value;
		logic               have_good_value;
	} hist_t;

	typedef struct packed {
		logic [5:0] faults;
		logic       take_value;  // fresh sample passed range and rate checks
	} det_t;

endpackage

// ===== design/fault_supervisor_fsm.sv =====
// Fault supervisor top level: input stage, detectors, supervisor state machine, result register.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one control tick per transaction:
//    time, sensor sample with fresh flag, command fresh flag, overflow,
//    missed check-in and manual clear.
//  - Output channel (out_valid/out_ready) returns exactly one result per tick:
//    mode, drive_enable, fault_bits, attempts and the three event counters.
//  - A tick passes through the input stage, then the result register. One tick
//    per cycle while the receiver takes results; the supervisor state updates on
//    the edge that moves a tick from the input stage into the result register.
//  - When the receiver stalls the result register holds; the input stage
//    still takes one more tick, after which in_ready drops until the
//    result is taken.
//  - Reset (arst_n low) returns config and state registers to their defaults,
//    mode to init, clears all history and counters, and empties both stages.
//  - Configuration: cfg_we writes cfg_data into register cfg_index with no
//    read-back; write only while no tick is in flight.
module fault_supervisor_fsm import fsup_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	// tick channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        tick_time,
	input  logic               sample_fresh,
	input  logic signed [15:0] sample_value,
	input  logic               cmd_fresh,
	input  logic               queue_overflow,
	input  logic               task_missed,
	input  logic               manual_clear,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         mode,
	output logic               drive_enable,
	output logic [5:0]         fault_bits,
	output logic [3:0]         attempts,
	output logic [31:0]        fault_count,
	output logic [31:0]        recovery_count,
	output logic [31:0]        latch_count
);

	`include "assert_macros.svh"

	typedef enum logic [2:0] {
		M_INIT       = 3'd0,
		M_NORMAL     = 3'd1,
		M_WARNING    = 3'd2,
		M_FAULT      = 3'd3,
		M_SAFE       = 3'd4,
		M_RECOVERING = 3'd5,
		M_LATCHED    = 3'd6
	} mode_t;

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_low      <= 16'sh8000;
			cfg_q.sensor_high     <= 16'sh7FFF;
			cfg_q.sensor_step     <= 16'hFFFF;
			cfg_q.warn_level      <= 16'sh7FFF;
			cfg_q.sensor_deadline <= 32'd100;
			cfg_q.comms_deadline  <= 32'd500;
			cfg_q.cooldown        <= 32'd1000;
			cfg_q.retry_limit     <= 4'd3;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SENSOR_LOW:   cfg_q.sensor_low      <= cfg_data[15:0];
				REG_SENSOR_HIGH:  cfg_q.sensor_high     <= cfg_data[15:0];
				REG_SENSOR_STEP:  cfg_q.sensor_step     <= cfg_data[15:0];
				REG_WARN_LEVEL:   cfg_q.warn_level      <= cfg_data[15:0];
				REG_SENSOR_DEADL: cfg_q.sensor_deadline <= cfg_data;
				REG_COMMS_DEADL:  cfg_q.comms_deadline  <= cfg_data;
				REG_COOLDOWN:     cfg_q.cooldown        <= cfg_data;
				REG_RETRY_LIMIT:  cfg_q.retry_limit     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// ---------------- input stage ----------------
	logic  valid_s1;
	tick_t tick_s1;
	logic  advance;

	// a tick in s1 moves on whenever the result register is free or being drained
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tick_s1.tick_time      <= tick_time;
			tick_s1.sample_fresh   <= sample_fresh;
			tick_s1.sample_value   <= sample_value;
			tick_s1.cmd_fresh      <= cmd_fresh;
			tick_s1.queue_overflow <= queue_overflow;
			tick_s1.task_missed    <= task_missed;
			tick_s1.manual_clear   <= manual_clear;
		end
	end

	// ---------------- supervisor state ----------------
	mode_t                mode_q;
	hist_t                hist_q;
	logic [31:0]          entry_time_q;
	logic [STREAK_W-1:0]  streak_q;
	logic [3:0]           attempt_q;
	logic [31:0]          fault_cnt_q;
	logic [31:0]          recov_cnt_q;
	logic [31:0]          latch_cnt_q;

	det_t det;

	fsup_detect u_detect (
		.cfg  (cfg_q),
		.tick (tick_s1),
		.hist (hist_q),
		.det  (det)
	);

	mode_t               target;
	mode_t               mode_n;
	hist_t               hist_n;
	logic [31:0]         entry_time_n;
	logic [STREAK_W-1:0] streak_inc;
	logic [STREAK_W-1:0] streak_n;
	logic [3:0]          attempt_n;
	logic [31:0]         fault_cnt_n;
	logic [31:0]         recov_cnt_n;
	logic [31:0]         latch_cnt_n;
	logic                any_fault;
	logic [31:0]         safe_age;

	assign any_fault = |det.faults;
	assign safe_age  = tick_s1.tick_time - entry_time_q;
	assign streak_inc = (streak_q != {STREAK_W{1'b1}}) ? streak_q + 1'b1 : streak_q;

	always_comb begin
		// history: stamp fresh items, keep the sample only if it checked out
		hist_n = hist_q;
		if (tick_s1.sample_fresh)
			hist_n.last_sample_time = tick_s1.tick_time;
		if (tick_s1.cmd_fresh)
			hist_n.last_command_time = tick_s1.tick_time;
		if (det.take_value) begin
			hist_n.last_good_value = tick_s1.sample_value;
			hist_n.have_good_value = 1'b1;
		end

		target      = mode_q;
		streak_n    = streak_q;
		attempt_n   = attempt_q;
		fault_cnt_n = fault_cnt_q;
		recov_cnt_n = recov_cnt_q;
		latch_cnt_n = latch_cnt_q;

		case (mode_q)
			M_INIT: begin
				if (any_fault) begin
					fault_cnt_n = fault_cnt_q + 32'd1;
					target = M_FAULT;
				end else if (tick_s1.sample_fresh) begin
					target = M_NORMAL;
				end
			end
			M_NORMAL: begin
				if (any_fault) begin
					fault_cnt_n = fault_cnt_q + 32'd1;
					target = M_FAULT;
				end else if (tick_s1.sample_fresh && tick_s1.sample_value >= cfg_q.warn_level) begin
					target = M_WARNING;
				end
			end
			M_WARNING: begin
				if (any_fault) begin
					fault_cnt_n = fault_cnt_q + 32'd1;
					target = M_FAULT;
				end else if (tick_s1.sample_fresh && tick_s1.sample_value < cfg_q.warn_level) begin
					target = M_NORMAL;
				end
			end
			M_FAULT: begin
				target = M_SAFE;
			end
			M_SAFE: begin
				// cooldown done: retry, or latch once retries are spent
				if (safe_age >= cfg_q.cooldown) begin
					if (attempt_q >= cfg_q.retry_limit) begin
						latch_cnt_n = latch_cnt_q + 32'd1;
						target = M_LATCHED;
					end else begin
						attempt_n = attempt_q + 4'd1;
						target = M_RECOVERING;
					end
				end
			end
			M_RECOVERING: begin
				if (any_fault) begin
					fault_cnt_n = fault_cnt_q + 32'd1;
					target = M_FAULT;
				end else if (tick_s1.sample_fresh) begin
					streak_n = streak_inc;
					if (streak_inc >= STREAK_W'(GOOD_SAMPLES_NEEDED)) begin
						recov_cnt_n = recov_cnt_q + 32'd1;
						attempt_n = '0;
						target = M_NORMAL;
					end
				end
			end
			M_LATCHED: begin
				if (tick_s1.manual_clear) begin
					attempt_n = '0;
					target = M_INIT;
				end
			end
			default: begin
				// unused code: go to fault, no event counted
				target = M_FAULT;
			end
		endcase

		// a change of mode stamps the entry time and restarts the streak
		mode_n       = target;
		entry_time_n = entry_time_q;
		if (target != mode_q) begin
			entry_time_n = tick_s1.tick_time;
			streak_n     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_INIT;
			hist_q       <= '0;
			entry_time_q <= '0;
			streak_q     <= '0;
			attempt_q    <= '0;
			fault_cnt_q  <= '0;
			recov_cnt_q  <= '0;
			latch_cnt_q  <= '0;
		end else if (advance) begin
			mode_q       <= mode_n;
			hist_q       <= hist_n;
			entry_time_q <= entry_time_n;
			streak_q     <= streak_n;
			attempt_q    <= attempt_n;
			fault_cnt_q  <= fault_cnt_n;
			recov_cnt_q  <= recov_cnt_n;
			latch_cnt_q  <= latch_cnt_n;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode           <= mode_n;
			drive_enable   <= (mode_n == M_NORMAL) || (mode_n == M_WARNING);
			fault_bits     <= det.faults;
			attempts       <= attempt_n;
			fault_count    <= fault_cnt_n;
			recovery_count <= recov_cnt_n;
			latch_count    <= latch_cnt_n;
		end
	end

	// ---------------- assertions ----------------
	// a mode change must stamp the tick's time as the entry time
	`ASSERT_NEXT(a_entry_stamp, clk, arst_n, advance && (mode_n != mode_q), entry_time_q == $past(tick_s1.tick_time))
	// the fault counter moves by at most one per tick
	`ASSERT_NEXT(a_fault_cnt_step, clk, arst_n, advance, (fault_cnt_q == $past(fault_cnt_q)) || (fault_cnt_q == $past(fault_cnt_q) + 32'd1))
	// a shown result agrees with the supervisor state it was taken from
	`ASSERT_NEXT(a_result_mode, clk, arst_n, advance, (mode == mode_q) && (attempts == attempt_q))

endmodule

// ===== design/fsup_detect.sv =====
// Fault detectors: timeouts, range, rate, overflow and task checks for one tick.
module fsup_detect import fsup_pkg::*; (
	input  cfg_t  cfg,
	input  tick_t tick,
	input  hist_t hist,
	output det_t  det
);

	logic signed [16:0] diff;
	logic        [16:0] abs_diff;
	logic        [31:0] sample_age;
	logic        [31:0] command_age;
	logic               implausible;
	logic               rate_bad;

	// wrapping time differences
	assign sample_age  = tick.tick_time - hist.last_sample_time;
	assign command_age = tick.tick_time - hist.last_command_time;

	assign diff = 17'(tick.sample_value) - 17'(hist.last_good_value);
	assign abs_diff = diff[16] ? 17'(-diff) : 17'(diff);

	assign implausible = tick.sample_fresh &&
		(tick.sample_value < cfg.sensor_low || tick.sample_value > cfg.sensor_high);
	assign rate_bad = tick.sample_fresh && hist.have_good_value &&
		(abs_diff > {1'b0, cfg.sensor_step});

	always_comb begin
		det.faults = '0;
		det.faults[FB_TIMEOUT]     = !tick.sample_fresh && (sample_age > cfg.sensor_deadline);
		det.faults[FB_IMPLAUSIBLE] = implausible;
		det.faults[FB_RATE]        = rate_bad;
		det.faults[FB_COMMS]       = !tick.cmd_fresh &&
			(command_age > cfg.comms_deadline);
		det.faults[FB_OVERFLOW]    = tick.queue_overflow;
		det.faults[FB_TASK]        = tick.task_missed;
		det.take_value = tick.sample_fresh && !implausible && !rate_bad;
	end

endmodule
